>>> hdl/two_bank_merge_sort_defines.svh
// assertion macros used by the checker file
`ifndef TWO_BANK_MERGE_SORT_DEFINES_SVH
`define TWO_BANK_MERGE_SORT_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define TBMS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define TBMS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/tbms_pkg.sv
`default_nettype none

package tbms_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int NUM_LANES   = 8;
    localparam int BANK_LANES  = 4;
    localparam int NET_LAYERS  = 6;
    localparam int COUNT_W     = $clog2(NUM_LANES + 1);
    localparam int LANE_IDX_W  = $clog2(NUM_LANES);

    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;
    localparam logic REG_SORT_ENABLE = 1'b0;

    localparam logic BANK_A = 1'b0;
    localparam logic BANK_B = 1'b1;

    // odd-even merge network, partner lane per layer (self means pass)
    localparam logic [LANE_IDX_W-1:0] NET_PARTNER [0:NET_LAYERS-1][0:NUM_LANES-1] = '{
        '{3'd1, 3'd0, 3'd3, 3'd2, 3'd5, 3'd4, 3'd7, 3'd6},
        '{3'd2, 3'd3, 3'd0, 3'd1, 3'd6, 3'd7, 3'd4, 3'd5},
        '{3'd0, 3'd2, 3'd1, 3'd3, 3'd4, 3'd6, 3'd5, 3'd7},
        '{3'd4, 3'd5, 3'd6, 3'd7, 3'd0, 3'd1, 3'd2, 3'd3},
        '{3'd0, 3'd1, 3'd4, 3'd5, 3'd2, 3'd3, 3'd6, 3'd7},
        '{3'd0, 3'd2, 3'd1, 3'd4, 3'd3, 3'd6, 3'd5, 3'd7}
    };

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_in_0;
        logic signed [SAMPLE_BITS-1:0] sample_in_1;
        logic signed [SAMPLE_BITS-1:0] sample_in_2;
        logic signed [SAMPLE_BITS-1:0] sample_in_3;
        logic signed [SAMPLE_BITS-1:0] sample_in_4;
        logic signed [SAMPLE_BITS-1:0] sample_in_5;
        logic signed [SAMPLE_BITS-1:0] sample_in_6;
        logic signed [SAMPLE_BITS-1:0] sample_in_7;
        logic [NUM_LANES-1:0]          linked_mask;
        logic                          bank_a_linked;
        logic                          bank_b_linked;
    } t_in_req;

    typedef struct packed {
        logic                          bank_id;
        logic signed [SAMPLE_BITS-1:0] slot_0;
        logic signed [SAMPLE_BITS-1:0] slot_1;
        logic signed [SAMPLE_BITS-1:0] slot_2;
        logic signed [SAMPLE_BITS-1:0] slot_3;
        logic signed [SAMPLE_BITS-1:0] slot_4;
        logic signed [SAMPLE_BITS-1:0] slot_5;
        logic signed [SAMPLE_BITS-1:0] slot_6;
        logic signed [SAMPLE_BITS-1:0] slot_7;
        logic [COUNT_W-1:0]            channel_count;
        logic                          frame_done;
    } t_out_req;

    // flag marks a lane at or beyond the count: sorts above every value
    typedef struct packed {
        logic                          flag;
        logic signed [SAMPLE_BITS-1:0] val;
    } t_lane;

    typedef t_lane [NUM_LANES-1:0] t_lanes;

    typedef struct packed {
        logic               bank_id;
        logic               sort;
        logic [COUNT_W-1:0] count;
        t_lanes             lanes;
    } t_bank;

endpackage

`default_nettype wire

>>> hdl/two_bank_merge_sort.sv
// channel  | dir | handshake           | payload
// ---------+-----+---------------------+-------------------------
// frame    | in  | i_valid / o_ready   | i_data (t_in_req)
// bank     | out | o_valid / i_ready   | o_data (t_out_req)
// config   | in  | psel/penable/pwrite | paddr, pwdata, prdata
//
// the frame register issues bank A then bank B into one six-layer sort pipeline,
// one bank request per cycle while the output is not held
// bank A passes the frame register, stages s1 to s4 and the output register; bank B follows it
// synchronous active-low reset clears all valid bits and sort_enable
// a held output freezes the whole pipeline; frames with no output linked are dropped
`default_nettype none

module two_bank_merge_sort (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_valid,
    output logic                               o_ready,
    input  wire  tbms_pkg::t_in_req            i_data,
    output logic                               o_valid,
    input  wire                                i_ready,
    output tbms_pkg::t_out_req                 o_data,
    input  wire                                psel,
    input  wire                                penable,
    input  wire                                pwrite,
    input  wire  [tbms_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire  [tbms_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [tbms_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready
);
    import tbms_pkg::*;

    function automatic logic lane_gt(input t_lane a, input t_lane b);
        lane_gt = (a.flag && !b.flag) ||
                  ((a.flag == b.flag) && ($signed(a.val) > $signed(b.val)));
    endfunction

    function automatic t_lanes net_layer(input t_lanes a, input int unsigned layer,
                                         input logic sort);
        t_lanes                r;
        logic [LANE_IDX_W-1:0] p;
        logic                  gt;
        for (int i = 0; i < NUM_LANES; i++) begin
            p  = NET_PARTNER[layer][i];
            gt = (LANE_IDX_W'(i) < p) ? lane_gt(a[i], a[p]) : lane_gt(a[p], a[i]);
            r[i] = (sort && gt && (p != LANE_IDX_W'(i))) ? a[p] : a[i];
        end
        return r;
    endfunction

    // configuration
    logic r_sort_enable;
    logic cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[APB_ADDR_W-1] == REG_SORT_ENABLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sort_enable <= 1'b0;
        end else if (cfg_wr) begin
            r_sort_enable <= pwdata[0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[APB_ADDR_W-1] == REG_SORT_ENABLE) begin
            prdata[0] = r_sort_enable;
        end
    end

    // pipeline advance: everything moves unless the output is held
    logic en;
    logic r_out_valid;
    assign en = !r_out_valid || i_ready;

    // frame register, issues bank A then bank B
    t_in_req r_fr;
    logic    r_fr_valid;
    logic    r_phase;
    logic    in_acc;

    assign o_ready = !r_fr_valid || (en && r_phase);
    assign in_acc  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fr_valid <= 1'b0;
            r_phase    <= 1'b0;
        end else if (in_acc) begin
            r_fr_valid <= i_data.bank_a_linked || i_data.bank_b_linked;
            r_phase    <= 1'b0;
        end else if (en && r_fr_valid) begin
            if (r_phase) begin
                r_fr_valid <= 1'b0;
            end else begin
                r_phase <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_fr <= i_data;
        end
    end

    // bank build: lane values, count and beyond-count flags
    logic signed [SAMPLE_BITS-1:0] smp [NUM_LANES];
    logic [NUM_LANES-1:0]          lm;
    logic signed [SAMPLE_BITS-1:0] raw [NUM_LANES];
    logic [COUNT_W-1:0]            cnt;
    t_bank                         n_s1;

    always_comb begin
        smp[0] = r_fr.sample_in_0;
        smp[1] = r_fr.sample_in_1;
        smp[2] = r_fr.sample_in_2;
        smp[3] = r_fr.sample_in_3;
        smp[4] = r_fr.sample_in_4;
        smp[5] = r_fr.sample_in_5;
        smp[6] = r_fr.sample_in_6;
        smp[7] = r_fr.sample_in_7;

        lm = '0;
        for (int i = 0; i < NUM_LANES; i++) begin
            raw[i] = '0;
        end
        priority if (!r_phase) begin
            lm[BANK_LANES-1:0] = r_fr.linked_mask[BANK_LANES-1:0];
            for (int i = 0; i < BANK_LANES; i++) begin
                raw[i] = smp[i];
            end
        end else if (r_fr.bank_a_linked) begin
            lm[BANK_LANES-1:0] = r_fr.linked_mask[NUM_LANES-1:BANK_LANES];
            for (int i = 0; i < BANK_LANES; i++) begin
                raw[i] = smp[i + BANK_LANES];
            end
        end else begin
            // chain mode: bank B spans all inputs
            lm = r_fr.linked_mask;
            for (int i = 0; i < NUM_LANES; i++) begin
                raw[i] = smp[i];
            end
        end

        cnt = '0;
        for (int i = 0; i < NUM_LANES; i++) begin
            if (lm[i]) begin
                cnt = COUNT_W'(i + 1);
            end
        end

        n_s1.bank_id = r_phase ? BANK_B : BANK_A;
        n_s1.sort    = r_sort_enable;
        n_s1.count   = cnt;
        for (int i = 0; i < NUM_LANES; i++) begin
            n_s1.lanes[i].val  = lm[i] ? raw[i] : '0;
            n_s1.lanes[i].flag = (COUNT_W'(i) >= cnt);
        end
    end

    // sort stages, two network layers each
    t_bank r_s1, r_s2, r_s3, r_s4;
    logic  r_s1_valid, r_s2_valid, r_s3_valid, r_s4_valid;
    t_bank n_s2, n_s3, n_s4;

    always_comb begin
        n_s2       = r_s1;
        n_s2.lanes = net_layer(net_layer(r_s1.lanes, 0, r_s1.sort), 1, r_s1.sort);
        n_s3       = r_s2;
        n_s3.lanes = net_layer(net_layer(r_s2.lanes, 2, r_s2.sort), 3, r_s2.sort);
        n_s4       = r_s3;
        n_s4.lanes = net_layer(net_layer(r_s3.lanes, 4, r_s3.sort), 5, r_s3.sort);
    end

    // flagged lanes always hold zero, so slots beyond the count read zero
    t_out_req n_out;
    t_out_req r_out;

    always_comb begin
        n_out.bank_id       = r_s4.bank_id;
        n_out.slot_0        = r_s4.lanes[0].val;
        n_out.slot_1        = r_s4.lanes[1].val;
        n_out.slot_2        = r_s4.lanes[2].val;
        n_out.slot_3        = r_s4.lanes[3].val;
        n_out.slot_4        = r_s4.lanes[4].val;
        n_out.slot_5        = r_s4.lanes[5].val;
        n_out.slot_6        = r_s4.lanes[6].val;
        n_out.slot_7        = r_s4.lanes[7].val;
        n_out.channel_count = r_s4.count;
        n_out.frame_done    = r_s4.bank_id;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_s4_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid  <= r_fr_valid;
            r_s2_valid  <= r_s1_valid;
            r_s3_valid  <= r_s2_valid;
            r_s4_valid  <= r_s3_valid;
            r_out_valid <= r_s4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1  <= n_s1;
            r_s2  <= n_s2;
            r_s3  <= n_s3;
            r_s4  <= n_s4;
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

`default_nettype wire

>>> hdl/tbms_checker.sv
`default_nettype none
`include "two_bank_merge_sort_defines.svh"

module tbms_checker (
    input wire                     i_clk,
    input wire                     i_rst_n,
    input wire                     o_valid,
    input wire                     i_ready,
    input wire tbms_pkg::t_out_req o_data
);
    import tbms_pkg::*;

    `TBMS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_data), "output request changed while stalled")
    `TBMS_ASSERT_NEXT(a_b_follows_a, i_clk, i_rst_n, o_valid && i_ready && (o_data.bank_id == BANK_A), o_valid && (o_data.bank_id == BANK_B), "bank B did not follow bank A")
    `TBMS_ASSERT_NOW(a_done_on_b, i_clk, i_rst_n, o_valid, o_data.frame_done == o_data.bank_id, "frame_done not on bank B")
    `TBMS_ASSERT_NOW(a_bank_a_narrow, i_clk, i_rst_n, o_valid && (o_data.bank_id == BANK_A), (o_data.channel_count <= COUNT_W'(BANK_LANES)) && (o_data.slot_4 == '0) && (o_data.slot_5 == '0) && (o_data.slot_6 == '0) && (o_data.slot_7 == '0), "bank A wider than four channels")

endmodule

bind two_bank_merge_sort tbms_checker u_tbms_checker (.*);

`default_nettype wire

>>> dv/tb_two_bank_merge_sort.sv
`timescale 1ns / 1ps

module tb_two_bank_merge_sort;

    import tbms_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int SETTLE_CYCLES = 12;
    localparam int RANDOM_CHUNKS = 8;
    localparam int FRAMES_PER_CHUNK = 116;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
    typedef t_sample t_sample_row [NUM_LANES];

    logic i_clk;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    t_in_req i_data = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    t_out_req o_data;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic pready;

    t_in_req pending_frames[$];
    t_out_req expected_banks[$];

    logic sort_on = 1'b0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int mismatches = 0;
    int frames_accepted = 0;
    int banks_checked = 0;
    int cycles = 0;

    two_bank_merge_sort uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_data(i_data),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_data(o_data),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // gather one bank, zero-fill unlinked slots, optionally insertion-sort the live part
    function automatic t_out_req merge_bank(input t_sample_row smp, input logic [7:0] mask,
                                            input int base, input int width, input logic id);
        t_sample_row v;
        t_sample key;
        int cnt;
        int i;
        int j;
        t_out_req r;
        cnt = 0;
        for (i = 0; i < NUM_LANES; i++) v[i] = '0;
        for (i = 0; i < width; i++) begin
            if (mask[base + i]) begin
                v[i] = smp[base + i];
                cnt = i + 1;
            end
        end
        if (sort_on) begin
            for (i = 1; i < cnt; i++) begin
                key = v[i];
                j = i;
                while (j > 0 && v[j - 1] > key) begin
                    v[j] = v[j - 1];
                    j--;
                end
                v[j] = key;
            end
        end
        r.bank_id = id;
        r.slot_0 = v[0];
        r.slot_1 = v[1];
        r.slot_2 = v[2];
        r.slot_3 = v[3];
        r.slot_4 = v[4];
        r.slot_5 = v[5];
        r.slot_6 = v[6];
        r.slot_7 = v[7];
        r.channel_count = COUNT_W'(cnt);
        r.frame_done = id;
        return r;
    endfunction

    function automatic void predict_frame(input t_in_req f);
        t_sample_row smp;
        if (!f.bank_a_linked && !f.bank_b_linked) return;
        smp = '{f.sample_in_0, f.sample_in_1, f.sample_in_2, f.sample_in_3,
                f.sample_in_4, f.sample_in_5, f.sample_in_6, f.sample_in_7};
        expected_banks.push_back(merge_bank(smp, f.linked_mask, 0, BANK_LANES, BANK_A));
        // chain mode folds all eight inputs into bank B
        if (f.bank_a_linked)
            expected_banks.push_back(merge_bank(smp, f.linked_mask, BANK_LANES, BANK_LANES,
                                                BANK_B));
        else
            expected_banks.push_back(merge_bank(smp, f.linked_mask, 0, NUM_LANES, BANK_B));
    endfunction

    function automatic void check_bank(input t_out_req got);
        t_out_req want;
        t_sample_row gs;
        t_sample_row ws;
        int i;
        if (expected_banks.size() == 0) begin
            $error("bank result with nothing expected: bank_id %0d", got.bank_id);
            mismatches++;
            return;
        end
        want = expected_banks.pop_front();
        banks_checked++;
        if (got.bank_id !== want.bank_id) begin
            $error("bank_id: expected %0d, got %0d", want.bank_id, got.bank_id);
            mismatches++;
        end
        gs = '{got.slot_0, got.slot_1, got.slot_2, got.slot_3,
               got.slot_4, got.slot_5, got.slot_6, got.slot_7};
        ws = '{want.slot_0, want.slot_1, want.slot_2, want.slot_3,
               want.slot_4, want.slot_5, want.slot_6, want.slot_7};
        for (i = 0; i < NUM_LANES; i++) begin
            if (gs[i] !== ws[i]) begin
                $error("slot_%0d: expected %0d, got %0d", i, ws[i], gs[i]);
                mismatches++;
            end
        end
        if (got.channel_count !== want.channel_count) begin
            $error("channel_count: expected %0d, got %0d", want.channel_count,
                   got.channel_count);
            mismatches++;
        end
        if (got.frame_done !== want.frame_done) begin
            $error("frame_done: expected %0d, got %0d", want.frame_done, got.frame_done);
            mismatches++;
        end
    endfunction

    // frame request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                predict_frame(i_data);
                frames_accepted++;
            end
            if (!i_valid || o_ready) begin
                if (pending_frames.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_data <= pending_frames.pop_front();
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // bank request monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) check_bank(o_data);
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("two_bank_merge_sort: mismatch");
            $finish;
        end
    end

    function automatic t_in_req mk_frame(input int s[NUM_LANES], input logic [7:0] mask,
                                         input logic a_on, input logic b_on);
        t_in_req f;
        f.sample_in_0 = SAMPLE_BITS'(s[0]);
        f.sample_in_1 = SAMPLE_BITS'(s[1]);
        f.sample_in_2 = SAMPLE_BITS'(s[2]);
        f.sample_in_3 = SAMPLE_BITS'(s[3]);
        f.sample_in_4 = SAMPLE_BITS'(s[4]);
        f.sample_in_5 = SAMPLE_BITS'(s[5]);
        f.sample_in_6 = SAMPLE_BITS'(s[6]);
        f.sample_in_7 = SAMPLE_BITS'(s[7]);
        f.linked_mask = mask;
        f.bank_a_linked = a_on;
        f.bank_b_linked = b_on;
        return f;
    endfunction

    // extremes and small values so that ties and sign crossings show up in sorting
    function automatic int rand_sample();
        case ($urandom_range(9))
            0: return 32767;
            1: return -32768;
            2, 3, 4: return int'($urandom_range(16)) - 8;
            default: return int'($urandom_range(65535)) - 32768;
        endcase
    endfunction

    function automatic t_in_req rand_frame();
        int s[NUM_LANES];
        logic [7:0] mask;
        logic [1:0] links;
        int i;
        for (i = 0; i < NUM_LANES; i++) s[i] = rand_sample();
        case ($urandom_range(7))
            0: mask = 8'h00;
            1: mask = 8'hFF;
            default: mask = 8'($urandom);
        endcase
        // mostly at least one output linked, a few dropped frames as noise
        if ($urandom_range(15) == 0) links = 2'b00;
        else links = 2'($urandom_range(1, 3));
        return mk_frame(s, mask, links[1], links[0]);
    endfunction

    task automatic write_sort(input logic en);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= APB_ADDR_W'(4 * int'(REG_SORT_ENABLE));
        pwdata <= APB_DATA_W'(en);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sort_on = en;
        @(negedge i_clk);
    endtask

    // dropped frames give no result, so let the pipeline empty after the last bank
    task automatic drain();
        while (pending_frames.size() != 0 || i_valid || expected_banks.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic load_directed();
        pending_frames.push_back(mk_frame('{32767, 32767, 32767, 32767, 32767, 32767,
                                            32767, 32767}, 8'hFF, 1'b1, 1'b1));
        pending_frames.push_back(mk_frame('{-32768, -32768, -32768, -32768, -32768, -32768,
                                            -32768, -32768}, 8'hFF, 1'b1, 1'b1));
        pending_frames.push_back(mk_frame('{7, 6, 5, -4, 3, -32768, 1, 32767},
                                          8'hFF, 1'b0, 1'b1));
        pending_frames.push_back(mk_frame('{1, 2, 3, 4, 5, 6, 7, 8}, 8'h00, 1'b1, 1'b1));
        pending_frames.push_back(mk_frame('{1, 2, 3, 4, 5, 6, 7, 8}, 8'h00, 1'b0, 1'b1));
        // nothing linked: frame is swallowed
        pending_frames.push_back(mk_frame('{9, 9, 9, 9, 9, 9, 9, 9}, 8'hFF, 1'b0, 1'b0));
        // gaps below the count read as zero and take part in the sort
        pending_frames.push_back(mk_frame('{-100, 200, -300, 400, -500, 600, -700, 800},
                                          8'h81, 1'b1, 1'b0));
        pending_frames.push_back(mk_frame('{-5, -6, -7, -8, -9, 10, 11, 12},
                                          8'h10, 1'b0, 1'b1));
        pending_frames.push_back(mk_frame('{32767, -1, 0, -32768, 1, -2, 32766, -32767},
                                          8'h5A, 1'b1, 1'b1));
        pending_frames.push_back(mk_frame('{3, 3, 3, 3, 3, 3, 3, -3}, 8'h80, 1'b0, 1'b1));
        pending_frames.push_back(mk_frame('{0, 0, 0, 0, 0, 0, 0, 0}, 8'hFF, 1'b0, 1'b0));
        pending_frames.push_back(mk_frame('{32767, -32768, 32767, -32768, 32767, -32768,
                                            32767, -32768}, 8'hFF, 1'b1, 1'b0));
    endtask

    initial begin
        int chunk;
        int k;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        write_sort(1'b0);
        load_directed();
        drain();
        write_sort(1'b1);
        load_directed();
        drain();

        for (chunk = 0; chunk < RANDOM_CHUNKS; chunk++) begin
            case (chunk / 2)
                0: begin send_idle_pct = 0; recv_stall_pct = 0; end
                1: begin send_idle_pct = 57; recv_stall_pct = 0; end
                2: begin send_idle_pct = 0; recv_stall_pct = 57; end
                default: begin send_idle_pct = 34; recv_stall_pct = 34; end
            endcase
            write_sort(chunk % 2 == 1);
            for (k = 0; k < FRAMES_PER_CHUNK; k++) pending_frames.push_back(rand_frame());
            drain();
        end

        $display("ran %0d frames with sorting off and on under four idle patterns",
                 frames_accepted);
        $display("%0d bank results compared, %0d field errors", banks_checked, mismatches);
        if (mismatches == 0) begin
            $display("two_bank_merge_sort: match");
        end else begin
            $display("two_bank_merge_sort: mismatch");
        end
        $finish;
    end

endmodule
